/* src/mle_pkg.sv */
package mle_pkg;

  // input operation codes
  typedef enum logic [2:0] {
    OP_BYTE    = 3'd0,
    OP_EOF     = 3'd1,
    OP_RDERR   = 3'd2,
    OP_TIMEOUT = 3'd3,
    OP_INTR    = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  // line status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOPASS  = 3'd1,
    ST_RDERR   = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_INTR    = 3'd4
  } status_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_EOF_CHAR    = 3'd0,
    REG_KILL_CHAR   = 3'd1,
    REG_ERASE_CHAR  = 3'd2,
    REG_FEEDBACK_ON = 3'd3,
    REG_BUFFER_SIZE = 3'd4
  } reg_idx_t;

  // classified command kinds
  typedef enum logic [3:0] {
    K_STORE,
    K_LINE_END,
    K_EOF,
    K_KILL,
    K_ERASE,
    K_RDERR,
    K_TIMEOUT,
    K_INTR,
    K_READ,
    K_IDLE
  } kind_t;

  localparam int DEF_BUF_DEPTH = 256;
  localparam int QDEPTH        = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 9;
  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  typedef struct packed {
    logic [7:0] eof_char;
    logic [7:0] kill_char;
    logic [7:0] erase_char;
    logic       feedback_on;
    logic [8:0] buffer_size;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
    logic [7:0] read_index;
  } cmd_t;

  typedef struct packed {
    logic       echo_star;
    logic [7:0] erase_count;
    logic       line_done;
    status_t    status;
    logic [7:0] line_length;
    logic [7:0] read_data;
  } res_t;

endpackage

/* src/mle_front.sv */
module mle_front
  import mle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [15:0] s_tdata,
  input  logic [2:0] s_tuser,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int LW = $clog2(QDEPTH + 1);

  cmd_t            queue [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [LW-1:0]   level;
  cmd_t            cmd_in;
  logic            push;
  logic [7:0]      ch;

  assign ch = s_tdata[7:0];

  // classify the incoming item
  always_comb begin
    cmd_in.byte_value = ch;
    cmd_in.read_index = s_tdata[15:8];
    case (op_t'(s_tuser))
      OP_BYTE: begin
        if (ch == CH_NL || ch == CH_CR) begin
          cmd_in.kind = K_LINE_END;
        end else if (cfg.feedback_on && ch == cfg.eof_char) begin
          cmd_in.kind = K_EOF;
        end else if (cfg.feedback_on && ch == cfg.kill_char) begin
          cmd_in.kind = K_KILL;
        end else if (cfg.feedback_on && ch == cfg.erase_char) begin
          cmd_in.kind = K_ERASE;
        end else begin
          cmd_in.kind = K_STORE;
        end
      end
      OP_EOF:     cmd_in.kind = K_EOF;
      OP_RDERR:   cmd_in.kind = K_RDERR;
      OP_TIMEOUT: cmd_in.kind = K_TIMEOUT;
      OP_INTR:    cmd_in.kind = K_INTR;
      OP_READ:    cmd_in.kind = K_READ;
      default:    cmd_in.kind = K_IDLE;
    endcase
  end

  assign s_tready = (level != LW'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (level != '0);
  assign q_cmd    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        level <= level + 1'b1;
      end else if (q_pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

/* src/mle_back.sv */
module mle_back
  import mle_pkg::*;
#(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  output logic m_tvalid,
  input  logic m_tready,
  output res_t res
);

  localparam int CW = $clog2(BUF_DEPTH);
  localparam int SW = $clog2(BUF_DEPTH + 1);
  localparam int XW = (SW > 9) ? SW : 9;

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    mem_q;
  logic          hit_q;

  logic [CW-1:0] stored_count;
  logic [CW-1:0] stored_count_next;
  logic          line_finished;
  logic          line_finished_next;
  logic          out_valid;
  res_t          out_q;
  res_t          res_next;

  logic          advance;
  logic          line_op;
  logic          small_buf;
  logic          line_end;
  logic          wr_en;
  logic [CW-1:0] base;
  logic [XW-1:0] size_x;
  logic [XW-1:0] cap;
  logic [XW-1:0] idx_x;
  logic          hit;

  function automatic logic [7:0] sat8(input logic [CW-1:0] v);
    logic [XW-1:0] w;
    w = XW'(v);
    sat8 = (w > XW'(255)) ? 8'hFF : w[7:0];
  endfunction

  assign advance = q_valid && (!out_valid || m_tready);
  assign q_pop   = advance;

  assign size_x    = (XW'(cfg.buffer_size) > XW'(BUF_DEPTH)) ? XW'(BUF_DEPTH)
                                                             : XW'(cfg.buffer_size);
  assign small_buf = (size_x < XW'(2));
  assign cap       = size_x - 1'b1;
  assign line_op   = (q_cmd.kind != K_READ) && (q_cmd.kind != K_IDLE);
  assign base      = (line_finished && line_op) ? '0 : stored_count;
  assign idx_x     = XW'(q_cmd.read_index);
  assign hit       = (q_cmd.kind == K_READ) && (idx_x < XW'(stored_count));

  always_comb begin
    stored_count_next  = base;
    line_finished_next = line_finished && !line_op;
    line_end           = 1'b0;
    wr_en              = 1'b0;
    res_next           = '0;
    res_next.status    = ST_OK;
    if (line_op && small_buf) begin
      line_end        = 1'b1;
      res_next.status = ST_RDERR;
    end else begin
      case (q_cmd.kind)
        K_STORE: begin
          wr_en              = 1'b1;
          stored_count_next  = base + 1'b1;
          res_next.echo_star = cfg.feedback_on;
          if (XW'(stored_count_next) >= cap) begin
            line_end = 1'b1;
          end
        end
        K_LINE_END: line_end = 1'b1;
        K_EOF: begin
          line_end        = 1'b1;
          res_next.status = (base == '0) ? ST_NOPASS : ST_OK;
        end
        K_KILL: begin
          res_next.erase_count = sat8(base);
          stored_count_next    = '0;
        end
        K_ERASE: begin
          if (base != '0) begin
            res_next.erase_count = 8'd1;
            stored_count_next    = base - 1'b1;
          end
        end
        K_RDERR: begin
          line_end        = 1'b1;
          res_next.status = ST_RDERR;
        end
        K_TIMEOUT: begin
          line_end        = 1'b1;
          res_next.status = ST_TIMEOUT;
        end
        K_INTR: begin
          line_end        = 1'b1;
          res_next.status = ST_INTR;
        end
        default: ;
      endcase
    end
    if (line_end) begin
      line_finished_next   = 1'b1;
      res_next.line_done   = 1'b1;
      res_next.erase_count = cfg.feedback_on ? sat8(stored_count_next) : 8'd0;
    end
    res_next.line_length = sat8(stored_count_next);
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      mem[base] <= q_cmd.byte_value;
    end
    if (advance) begin
      mem_q <= mem[idx_x[CW-1:0]];
      hit_q <= hit;
      out_q <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count  <= '0;
      line_finished <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        stored_count  <= stored_count_next;
        line_finished <= line_finished_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    res           = out_q;
    res.read_data = hit_q ? mem_q : 8'd0;
  end

endmodule

/* src/masked_line_input_editor.sv */
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tuser: operation; tdata: byte_value, read_index
// m_*       out  m_tvalid/m_tready   tdata: echo, erase, status, length, read data
//                                     tlast: line_done
// cfg_*     in   cfg_we              cfg_index selects register, cfg_data value
//
// one transaction per cycle sustained while the output is not stalled; an input is written
// to the queue, then executed into the output register together with the line store read
// the line store is a single-write, single-read memory; the execute unit updates
// the count and writes the store in the same cycle, so bytes follow back to back
// synchronous active-high reset clears counters, queue and output valid
// a stalled output holds its transaction; the two-entry queue keeps input moving
module masked_line_input_editor
  import mle_pkg::*;
#(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [7:0] byte_value, [15:8] read_index
  input  logic [2:0]            s_tuser,   // [2:0] operation
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,   // [0] echo_star, [8:1] erase_count,
                                           // [11:9] status, [19:12] line_length,
                                           // [27:20] read_data, rest zero
  output logic                  m_tlast,   // line_done
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  // configuration registers; the user must write them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eof_char    <= 8'd4;
      cfg.kill_char   <= 8'd21;
      cfg.erase_char  <= 8'd127;
      cfg.feedback_on <= 1'b1;
      cfg.buffer_size <= 9'd256;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_EOF_CHAR:    cfg.eof_char    <= cfg_data[7:0];
        REG_KILL_CHAR:   cfg.kill_char   <= cfg_data[7:0];
        REG_ERASE_CHAR:  cfg.erase_char  <= cfg_data[7:0];
        REG_FEEDBACK_ON: cfg.feedback_on <= cfg_data[0];
        REG_BUFFER_SIZE: cfg.buffer_size <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify into the command queue
  mle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // back: line state, line store and output register
  mle_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  // pack result fields from the lowest bit up
  assign m_tdata = {4'd0, res.read_data, res.line_length, res.status,
                    res.erase_count, res.echo_star};
  assign m_tlast = res.line_done;

`ifndef SYNTHESIS
  // a status other than ok only comes with a finished line
  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[11:9] == ST_OK)
    else $error("status set without line end");

  // a stored byte that does not end the line never asks for erasing
  a_echo_no_erase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && !m_tlast |-> m_tdata[8:1] == 8'd0)
    else $error("star echo together with erase");

  // a star echo means at least one byte is stored
  a_echo_has_length: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[19:12] != 8'd0)
    else $error("star echo with empty line");

  // a new result only appears after the queue held a command
  a_result_from_queue: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(q_valid))
    else $error("result without queued command");
`endif

endmodule

/* tb/tb_masked_line_input_editor.sv */
import mle_pkg::*;

// mirrors the line editor: configuration, line store and counters, and the
// queue of results still owed by the block
class line_editor_scoreboard;
  logic [7:0] eof_char;
  logic [7:0] kill_char;
  logic [7:0] erase_char;
  logic       feedback;
  logic [8:0] buf_size;

  logic [7:0] line_store [DEF_BUF_DEPTH];
  int         stored;
  int         written_top;   // entries below this were written at least once
  bit         finished;

  res_t       expected_results [$];
  int         errors;
  int         checked;
  int         lines_ended;

  function new();
    eof_char    = 8'd4;
    kill_char   = 8'd21;
    erase_char  = 8'd127;
    feedback    = 1'b1;
    buf_size    = 9'd256;
    stored      = 0;
    written_top = 0;
    finished    = 1'b0;
    errors      = 0;
    checked     = 0;
    lines_ended = 0;
  endfunction

  function void set_reg(reg_idx_t r, logic [8:0] v);
    case (r)
      REG_EOF_CHAR:    eof_char   = v[7:0];
      REG_KILL_CHAR:   kill_char  = v[7:0];
      REG_ERASE_CHAR:  erase_char = v[7:0];
      REG_FEEDBACK_ON: feedback   = v[0];
      REG_BUFFER_SIZE: buf_size   = v;
      default: ;
    endcase
  endfunction

  function logic [7:0] clip255(int v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // works out the result of one accepted transaction and queues it
  function void predict_result(logic [2:0] op, logic [7:0] c, logic [7:0] idx);
    res_t r;
    int   size;
    bit   ended;
    r     = '0;
    ended = 1'b0;
    if (op <= OP_INTR) begin
      size = (buf_size > DEF_BUF_DEPTH) ? DEF_BUF_DEPTH : int'(buf_size);
      if (finished) begin
        stored   = 0;
        finished = 1'b0;
      end
      if (size < 2) begin
        ended    = 1'b1;
        r.status = ST_RDERR;
      end else if (op == OP_BYTE) begin
        if (c == CH_NL || c == CH_CR) begin
          ended    = 1'b1;
          r.status = ST_OK;
        end else if (feedback && c == eof_char) begin
          ended    = 1'b1;
          r.status = (stored == 0) ? ST_NOPASS : ST_OK;
        end else if (feedback && c == kill_char) begin
          r.erase_count = clip255(stored);
          stored        = 0;
        end else if (feedback && c == erase_char) begin
          if (stored > 0) begin
            r.erase_count = 8'd1;
            stored--;
          end
        end else begin
          if (stored < DEF_BUF_DEPTH) line_store[stored] = c;
          stored++;
          if (stored > written_top) written_top = stored;
          r.echo_star = feedback;
          if (stored >= size - 1) begin
            ended    = 1'b1;
            r.status = ST_OK;
          end
        end
      end else begin
        ended = 1'b1;
        case (op)
          OP_EOF:     r.status = (stored == 0) ? ST_NOPASS : ST_OK;
          OP_RDERR:   r.status = ST_RDERR;
          OP_TIMEOUT: r.status = ST_TIMEOUT;
          default:    r.status = ST_INTR;
        endcase
      end
      if (ended) begin
        r.line_done   = 1'b1;
        finished      = 1'b1;
        r.erase_count = feedback ? clip255(stored) : 8'd0;
        lines_ended++;
      end
    end else if (op == OP_READ) begin
      if (idx < stored) r.read_data = line_store[idx];
    end
    r.line_length = clip255(stored);
    expected_results.push_back(r);
  endfunction

  task report(string what, int got, int want);
    errors++;
    if (errors <= 50)
      $display("bad %s on result %0d: got %0d, want %0d", what, checked, got, want);
  endtask

  // compares one accepted output transaction with the oldest expectation
  task check_result(logic [31:0] data, logic last);
    res_t want;
    if (expected_results.size() == 0) begin
      report("result with nothing pending, tdata", int'(data), 0);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    if (data[0] !== want.echo_star)
      report("echo_star", int'(data[0]), int'(want.echo_star));
    if (data[8:1] !== want.erase_count)
      report("erase_count", int'(data[8:1]), int'(want.erase_count));
    if (data[11:9] !== want.status)
      report("status", int'(data[11:9]), int'(want.status));
    if (data[19:12] !== want.line_length)
      report("line_length", int'(data[19:12]), int'(want.line_length));
    if (data[27:20] !== want.read_data)
      report("read_data", int'(data[27:20]), int'(want.read_data));
    if (data[31:28] !== 4'd0)
      report("tdata padding", int'(data[31:28]), 0);
    if (last !== want.line_done)
      report("line_done", int'(last), int'(want.line_done));
  endtask
endclass

module tb_masked_line_input_editor;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transaction before the run is given up
  localparam int STALL_LIMIT = 3000;
  // pipeline depth plus margin, waited out after the last result
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] byte_value, [15:8] read_index
  logic [2:0]  s_tuser = '0;   // [2:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [0] echo_star, [8:1] erase_count, [11:9] status,
                               // [19:12] line_length, [27:20] read_data
  logic        m_tlast;        // line_done
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  line_editor_scoreboard sb;

  int items_sent = 0;
  int send_idle  = 11;   // percent of cycles the sender holds back
  int recv_idle  = 71;   // percent of cycles the receiver stalls
  int stall_cycles = 0;
  int settings_applied = 0;

  reg_idx_t reg_order [5] = '{REG_EOF_CHAR, REG_KILL_CHAR, REG_ERASE_CHAR,
                              REG_FEEDBACK_ON, REG_BUFFER_SIZE};

  masked_line_input_editor uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted transactions, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog: any transaction on either stream restarts the count
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("masked_line_input_editor: mismatch");
      $finish;
    end
  end

  // one input transaction; entered and left just after a rising edge
  task automatic send_item(logic [2:0] op, logic [7:0] c, logic [7:0] idx);
    // idling pattern moves through three stretches of the run
    if (items_sent < 350) begin
      send_idle = 11;
      recv_idle = 71;
    end else if (items_sent < 700) begin
      send_idle = 71;
      recv_idle = 11;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {idx, c};
    do @(posedge clk); while (!s_tready);
    sb.predict_result(op, c, idx);
    items_sent++;
  endtask

  // writes all five registers; only called with nothing in flight
  task automatic apply_config(logic [7:0] e, logic [7:0] k, logic [7:0] er,
                              logic fb, logic [8:0] sz);
    logic [8:0] vals [5];
    vals[0] = {1'b0, e};
    vals[1] = {1'b0, k};
    vals[2] = {1'b0, er};
    vals[3] = {8'd0, fb};
    vals[4] = sz;
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_order[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(reg_order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  // stop sending and let every owed result come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // a byte that the current setting stores as an ordinary character
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom);
    end while (c == CH_NL || c == CH_CR ||
               (sb.feedback && (c == sb.eof_char || c == sb.kill_char ||
                                c == sb.erase_char)));
    return c;
  endfunction

  // reads only ever touch entries that were written since reset
  task automatic send_read();
    if (sb.written_top == 0)
      send_item(OP_BYTE, plain_byte(), 8'($urandom));
    else
      send_item(OP_READ, 8'($urandom), 8'($urandom_range(sb.written_top - 1)));
  endtask

  task automatic send_noise();
    logic [2:0] op;
    op = 3'($urandom_range(7));
    if (op == OP_READ)
      send_read();
    else
      send_item(op, 8'($urandom), 8'($urandom));
  endtask

  // one line: ordinary bytes mixed with edits and reads, then some ending
  task automatic send_line(int len);
    int k;
    for (int i = 0; i < len; i++) begin
      k = $urandom_range(99);
      if (k < 80)
        send_item(OP_BYTE, plain_byte(), 8'($urandom));
      else if (k < 88)
        send_item(OP_BYTE, sb.erase_char, 8'($urandom));
      else if (k < 91 && len <= 20)
        send_item(OP_BYTE, sb.kill_char, 8'($urandom));
      else
        send_read();
    end
    case ($urandom_range(6))
      0: send_item(OP_BYTE, CH_NL, 8'($urandom));
      1: send_item(OP_BYTE, CH_CR, 8'($urandom));
      2: send_item(OP_BYTE, sb.eof_char, 8'($urandom));
      3: send_item(OP_EOF, 8'($urandom), 8'($urandom));
      4: send_item(OP_RDERR, 8'($urandom), 8'($urandom));
      5: send_item(OP_TIMEOUT, 8'($urandom), 8'($urandom));
      default: send_item(OP_INTR, 8'($urandom), 8'($urandom));
    endcase
  endtask

  // random traffic under the current setting, mostly whole lines
  task automatic run_phase(int count);
    int target;
    int size_eff;
    int len;
    target   = items_sent + count;
    size_eff = (sb.buf_size > DEF_BUF_DEPTH) ? DEF_BUF_DEPTH : int'(sb.buf_size);
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        // now and then a line long enough to fill a big buffer
        if (size_eff >= 200 && target - items_sent > 150 && $urandom_range(14) == 0)
          len = $urandom_range(130, 260);
        else
          len = $urandom_range(12);
        send_line(len);
      end else begin
        send_noise();
      end
    end
  endtask

  initial begin
    logic [7:0] e, k, er;
    logic       fb;
    logic [8:0] sz;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset setting: fb on, size 256, eof 4, kill 21,
    // erase 127
    send_item(OP_EOF, 8'h00, 8'hFF);          // eof on an empty line
    send_item(OP_BYTE, 8'h61, 8'h00);
    send_item(OP_BYTE, 8'hFF, 8'hFF);
    send_item(OP_BYTE, 8'h00, 8'h00);
    send_item(OP_READ, 8'hFF, 8'd0);
    send_item(OP_READ, 8'h00, 8'd2);
    send_item(OP_BYTE, 8'd127, 8'h00);        // erase
    send_item(OP_READ, 8'h00, 8'd2);          // written but past the line end
    send_item(OP_BYTE, 8'd21, 8'h00);         // kill empties the line
    send_item(OP_BYTE, 8'd127, 8'h00);        // erase with nothing stored
    send_item(OP_BYTE, 8'h78, 8'h00);
    send_item(OP_BYTE, CH_NL, 8'h00);
    send_item(OP_BYTE, 8'h79, 8'h00);         // next line starts fresh
    send_item(OP_BYTE, CH_CR, 8'h00);
    send_item(OP_BYTE, 8'h7A, 8'h00);
    send_item(OP_BYTE, 8'd4, 8'h00);          // eof char with a stored byte
    send_item(OP_BYTE, 8'h71, 8'h00);
    send_item(OP_EOF, 8'h00, 8'h00);
    send_item(OP_RDERR, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'h77, 8'h00);
    send_item(OP_TIMEOUT, 8'h00, 8'h00);
    send_item(OP_BYTE, 8'h76, 8'h00);
    send_item(OP_INTR, 8'h00, 8'h00);
    send_item(OP_READ, 8'h00, 8'd0);          // still readable after interrupt
    send_item(3'd6, 8'hFF, 8'hFF);            // unused codes are ignored
    send_item(3'd7, 8'h00, 8'h00);
    wait_idle();

    // register settings, fixed extremes first, then random ones mixed with one more fixed setting
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin e = 8'd0;   k = 8'd0;   er = 8'd0;   fb = 1'b1; sz = 9'd2;   end
        1: begin e = 8'd255; k = 8'd8;   er = 8'd8;   fb = 1'b1; sz = 9'd20;  end
        2: begin e = 8'd4;   k = 8'd21;  er = 8'd127; fb = 1'b0; sz = 9'd256; end
        3: begin e = 8'd3;   k = 8'd255; er = 8'd8;   fb = 1'b1; sz = 9'd256; end
        4: begin e = 8'd4;   k = 8'd21;  er = 8'd127; fb = 1'b1; sz = 9'd1;   end
        5: begin e = 8'd9;   k = 8'd10;  er = 8'd13;  fb = 1'b1; sz = 9'd0;   end
        6: begin e = 8'd4;   k = 8'd21;  er = 8'd127; fb = 1'b1; sz = 9'd511; end
        8: begin e = 8'd3;   k = 8'd21;  er = 8'd8;   fb = 1'b1; sz = 9'd256; end
        default: begin
          e  = 8'($urandom);
          k  = 8'($urandom);
          er = 8'($urandom);
          fb = 1'($urandom_range(1));
          sz = ($urandom_range(3) == 0) ? 9'($urandom_range(511))
                                        : 9'($urandom_range(2, 64));
        end
      endcase
      apply_config(e, k, er, fb, sz);
      // a buffer below two ends every line at once, so fewer items there
      run_phase((sz < 9'd2) ? 30 : 115);
      wait_idle();
    end

    $display("sent %0d transactions, checked %0d results, %0d lines ended",
             items_sent, sb.checked, sb.lines_ended);
    $display("covered %0d register settings: feedback off, equal control chars, %s",
             settings_applied, "tiny and oversized buffers");
    if (sb.errors == 0)
      $display("masked_line_input_editor: match");
    else
      $display("masked_line_input_editor: mismatch");
    $finish;
  end
endmodule
